// ===== rtl/core/tccb_pkg.sv =====
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared types and constants of the text console cell buffer: grid geometry,
// character codes, command encoding between front and back, back-end states.
// ----------------------------------------------------------------------------
package tccb_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 128;
  localparam int RowW    = 6;
  localparam int ColW    = 7;
  localparam int AddrW   = RowW + ColW;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register index within the configuration space (paddr bit 2).
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       ch;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
  } cmd_t;

  // Effective geometry and a one-cycle pulse after any register write.
  typedef struct packed {
    logic            upd;
    logic [ColW:0]   cols;
    logic [RowW:0]   rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [RowW-1:0]  cursor_row;
    logic [ColW-1:0]  cursor_column;
    logic             scrolled;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_READ
  } back_state_e;

endpackage

// ===== rtl/core/tccb_front.sv =====
// ----------------------------------------------------------------------------
// tccb_front
// Accepts input beats, decodes them into back-end commands and holds them in
// a small queue so that the producer and the back end stall independently.
// ----------------------------------------------------------------------------
module tccb_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [7:0]                   char_code_i,
  input  logic [tccb_pkg::RowW-1:0]    read_row_i,
  input  logic [tccb_pkg::ColW-1:0]    read_column_i,
  output logic                         cmd_valid_o,
  output tccb_pkg::cmd_t               cmd_o,
  input  logic                         cmd_pop_i
);
  import tccb_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  cmd_t            cmd_new;
  logic            push;

  always_comb begin
    cmd_new.ch  = char_code_i;
    cmd_new.row = read_row_i;
    cmd_new.col = read_column_i;
    unique case (action_e'(action_i))
      ACT_PUT: begin
        if (char_code_i == CH_CR) begin
          cmd_new.kind = CMD_NOP;
        end else if (char_code_i == CH_LF) begin
          cmd_new.kind = CMD_NEWLINE;
        end else if (char_code_i == CH_BS) begin
          cmd_new.kind = CMD_BACKSPACE;
        end else begin
          cmd_new.kind = CMD_CHAR;
        end
      end
      ACT_READ:  cmd_new.kind = CMD_READ;
      ACT_CLEAR: cmd_new.kind = CMD_CLEAR;
      ACT_NONE:  cmd_new.kind = CMD_NOP;
    endcase
  end

  assign in_ready_o  = (count_q != CntW'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/core/tccb_back.sv =====
// ----------------------------------------------------------------------------
// tccb_back
// Executes queued commands against the cell memory and the cursor, and holds
// the result beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module tccb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  tccb_pkg::cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  input  tccb_pkg::cfg_t        cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tccb_pkg::res_t        res_o
);
  import tccb_pkg::*;

  typedef struct packed {
    logic            scroll;
    logic [RowW-1:0] row;
    logic [RowW-1:0] top;
    logic [RowW-1:0] blank_row;
  } lf_t;

  // Line feed: next row, or scroll when the last row in use is passed. The
  // blanked physical row is the old top plus the row count, modulo the ring.
  function automatic lf_t line_feed(logic [RowW-1:0] row, logic [RowW-1:0] top,
                                    logic [RowW:0] rows);
    lf_t        r;
    logic [RowW:0] nxt;
    nxt         = {1'b0, row} + (RowW+1)'(1);
    r.scroll    = (nxt >= rows);
    r.row       = r.scroll ? RowW'(rows - (RowW+1)'(1)) : nxt[RowW-1:0];
    r.top       = r.scroll ? top + RowW'(1) : top;
    r.blank_row = top + rows[RowW-1:0];
    return r;
  endfunction

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RowW-1:0]  top_q, top_d;
  logic [MaxRows-1:0] row_valid_q, row_valid_d;
  logic [ColW-1:0]  sweep_cnt_q, sweep_cnt_d;
  logic             scroll_q, scroll_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic [7:0]       mem_q [MaxRows*MaxCols];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata_q;

  logic [RowW-1:0]  cur_phys;
  logic [RowW-1:0]  rd_phys;
  logic [ColW:0]    col_inc;
  lf_t              lf;
  logic             done;
  logic [7:0]       done_cell;
  logic             done_scroll;

  assign cur_phys = top_q + cur_row_q;
  assign rd_phys  = top_q + cmd_q.row;
  assign col_inc  = {1'b0, cur_col_q} + (ColW+1)'(1);
  assign lf       = line_feed(cur_row_q, top_q, cfg_i.rows);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    top_d       = top_q;
    row_valid_d = row_valid_q;
    sweep_cnt_d = sweep_cnt_q;
    scroll_d    = scroll_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = {cur_phys, cur_col_q};
    mem_wdata   = CH_SPACE;
    mem_raddr   = {rd_phys, cmd_q.col};
    done        = 1'b0;
    done_cell   = 8'd0;
    done_scroll = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // A geometry change pulls the cursor back inside the grid.
    if (cfg_i.upd) begin
      if ({1'b0, cur_row_q} >= cfg_i.rows) begin
        cur_row_d = RowW'(cfg_i.rows - (RowW+1)'(1));
      end
      if ({1'b0, cur_col_q} >= cfg_i.cols) begin
        cur_col_d = ColW'(cfg_i.cols - (ColW+1)'(1));
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          scroll_d  = 1'b0;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_q.kind)
          CMD_NOP: begin
            done = 1'b1;
          end
          CMD_NEWLINE: begin
            cur_col_d = '0;
            cur_row_d = lf.row;
            top_d     = lf.top;
            if (lf.scroll) begin
              row_valid_d[lf.blank_row] = 1'b0;
            end
            done_scroll = lf.scroll;
            done        = 1'b1;
          end
          CMD_BACKSPACE: begin
            if (cur_col_q != '0) begin
              cur_col_d = cur_col_q - ColW'(1);
              mem_waddr = {cur_phys, cur_col_q - ColW'(1)};
              // A row that is not valid already reads as spaces.
              mem_we    = row_valid_q[cur_phys];
            end
            done = 1'b1;
          end
          CMD_CLEAR: begin
            row_valid_d = '0;
            top_d       = '0;
            cur_row_d   = '0;
            cur_col_d   = '0;
            done        = 1'b1;
          end
          CMD_READ: begin
            hit_d   = ({1'b0, cmd_q.row} < cfg_i.rows) &&
                      ({1'b0, cmd_q.col} < cfg_i.cols) && row_valid_q[rd_phys];
            state_d = ST_READ;
          end
          CMD_CHAR: begin
            if ({1'b0, cur_col_q} >= cfg_i.cols) begin
              // Wrap before the store; the store comes on a later pass.
              cur_col_d = '0;
              cur_row_d = lf.row;
              top_d     = lf.top;
              if (lf.scroll) begin
                row_valid_d[lf.blank_row] = 1'b0;
                scroll_d = 1'b1;
              end
            end else if (!row_valid_q[cur_phys]) begin
              state_d = ST_SWEEP;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = cmd_q.ch;
              if (col_inc >= cfg_i.cols) begin
                cur_col_d = '0;
                cur_row_d = lf.row;
                top_d     = lf.top;
                if (lf.scroll) begin
                  row_valid_d[lf.blank_row] = 1'b0;
                end
                done_scroll = scroll_q || lf.scroll;
              end else begin
                cur_col_d   = col_inc[ColW-1:0];
                done_scroll = scroll_q;
              end
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      ST_SWEEP: begin
        // Blank the whole physical row before its first store.
        mem_we    = 1'b1;
        mem_waddr = {cur_phys, sweep_cnt_q};
        if (sweep_cnt_q == ColW'(MaxCols - 1)) begin
          sweep_cnt_d           = '0;
          row_valid_d[cur_phys] = 1'b1;
          state_d               = ST_EXEC;
        end else begin
          sweep_cnt_d = sweep_cnt_q + ColW'(1);
        end
      end
      ST_READ: begin
        done_cell = hit_q ? mem_rdata_q : CH_SPACE;
        done      = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (done) begin
      out_valid_d         = 1'b1;
      res_d.cell_char     = done_cell;
      res_d.cursor_row    = cur_row_d;
      res_d.cursor_column = cur_col_d;
      res_d.scrolled      = done_scroll;
      state_d             = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      row_valid_q <= '0;
      sweep_cnt_q <= '0;
      scroll_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      top_q       <= top_d;
      row_valid_q <= row_valid_d;
      sweep_cnt_q <= sweep_cnt_d;
      scroll_q    <= scroll_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_pop_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !out_valid_q)
    else $error("command popped while a result beat is still pending");

  a_sweep_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SWEEP) |-> (sweep_cnt_q == '0))
    else $error("row fill counter not at zero outside a fill");

  a_no_write_when_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_READ) |-> !mem_we)
    else $error("cell memory written outside execution");

  a_fill_marks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sweep_cnt_q == ColW'(MaxCols - 1))
      |=> row_valid_q[$past(cur_phys)])
    else $error("filled row not marked valid");
`endif

endmodule

// ===== rtl/core/text_console_cell_buffer.sv =====
// Flow: an accepted beat is registered in the queue, then popped into the command register,
// and its result beat is registered at the end of execution; a read also passes the memory
// read state. A put into a row not stored to since reset, clear or scroll first blanks that
// row at one cell per cycle, and a wrap before the store adds another pass through execution.
// One item at a time: the next command only after the result beat is taken; a small queue keeps accepting meanwhile.
// Reset: no clearing pass; per-row valid bits make every cell read as space.
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// Character-cell console: grid store with ring scrolling, cursor handling and
// an APB-style port for the column and row counts in use.
// ----------------------------------------------------------------------------
module text_console_cell_buffer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [7:0]                   char_code_i,
  input  logic [tccb_pkg::RowW-1:0]    read_row_i,
  input  logic [tccb_pkg::ColW-1:0]    read_column_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   cell_char_o,
  output logic [tccb_pkg::RowW-1:0]    cursor_row_o,
  output logic [tccb_pkg::ColW-1:0]    cursor_column_o,
  output logic                         scrolled_o
);
  import tccb_pkg::*;

  logic [7:0] columns_q;
  logic [6:0] rows_q;
  logic       cfg_upd_q;
  logic       cfg_wr;
  cfg_t       cfg;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  res_t       res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 8'd128;
      rows_q    <= 7'd64;
      cfg_upd_q <= 1'b0;
    end else begin
      cfg_upd_q <= cfg_wr;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_COLUMNS: columns_q <= pwdata[7:0];
          REG_ROWS:    rows_q    <= pwdata[6:0];
          default:     columns_q <= columns_q;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLUMNS: prdata = {24'd0, columns_q};
      REG_ROWS:    prdata = {25'd0, rows_q};
      default:     prdata = '0;
    endcase
  end

  // Out-of-range counts are limited to one through the grid size.
  always_comb begin
    cfg.upd = cfg_upd_q;
    if (columns_q == '0) begin
      cfg.cols = (ColW+1)'(1);
    end else if (columns_q > 8'(MaxCols)) begin
      cfg.cols = (ColW+1)'(MaxCols);
    end else begin
      cfg.cols = (ColW+1)'(columns_q);
    end
    if (rows_q == '0) begin
      cfg.rows = (RowW+1)'(1);
    end else if (rows_q > 7'(MaxRows)) begin
      cfg.rows = (RowW+1)'(MaxRows);
    end else begin
      cfg.rows = (RowW+1)'(rows_q);
    end
  end

  tccb_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .char_code_i   (char_code_i),
    .read_row_i    (read_row_i),
    .read_column_i (read_column_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tccb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign cell_char_o     = res.cell_char;
  assign cursor_row_o    = res.cursor_row;
  assign cursor_column_o = res.cursor_column;
  assign scrolled_o      = res.scrolled;

endmodule

// ===== tb/tb_text_console_cell_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cell_buffer
// Self-checking bench for the text console cell buffer. A queue-fed driver
// offers put, read, clear and no-op beats with random gaps, a monitor checks
// every result beat against a cycle-free model of the grid and the cursor,
// and the geometry registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_text_console_cell_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import tccb_pkg::*;

  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          PHASES       = 13;
  localparam int          PHASE_ITEMS  = 100;
  localparam logic [2:0]  ADDR_COLUMNS = {REG_COLUMNS, 2'b00};
  localparam logic [2:0]  ADDR_ROWS    = {REG_ROWS, 2'b00};

  typedef struct {
    action_e          act;
    logic [7:0]       ch;
    logic [RowW-1:0]  rrow;
    logic [ColW-1:0]  rcol;
  } console_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i = '0;
  logic [7:0]        char_code_i = '0;
  logic [RowW-1:0]   read_row_i = '0;
  logic [ColW-1:0]   read_column_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        cell_char_o;
  logic [RowW-1:0]   cursor_row_o;
  logic [ColW-1:0]   cursor_column_o;
  logic              scrolled_o;

  text_console_cell_buffer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .char_code_i     (char_code_i),
    .read_row_i      (read_row_i),
    .read_column_i   (read_column_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cell_char_o     (cell_char_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_column_o (cursor_column_o),
    .scrolled_o      (scrolled_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the console: ring of physical rows, cursor and geometry.
  logic [7:0]   screen [MaxRows*MaxCols];
  int unsigned  top_ofs;
  int unsigned  cur_r;
  int unsigned  cur_c;
  int unsigned  col_setting;
  int unsigned  row_setting;

  console_item_t  pending[$];
  res_t           results_due[$];
  int             errors = 0;
  int             cycle_count = 0;
  bit             send_idle = 1'b1;
  bit             recv_idle = 1'b1;
  int             send_gap = 0;
  int             recv_gap = 0;
  int             hold_requests = 0;
  int             hold_served = 0;
  int             hold_left = 0;

  function automatic int unsigned cols_eff();
    if (col_setting < 1) return 1;
    if (col_setting > MaxCols) return MaxCols;
    return col_setting;
  endfunction

  function automatic int unsigned rows_eff();
    if (row_setting < 1) return 1;
    if (row_setting > MaxRows) return MaxRows;
    return row_setting;
  endfunction

  function automatic int unsigned cell_addr(int unsigned row, int unsigned col);
    return ((top_ofs + row) % MaxRows) * MaxCols + (col % MaxCols);
  endfunction

  function automatic void wipe_screen();
    foreach (screen[i]) screen[i] = CH_SPACE;
    top_ofs = 0;
    cur_r = 0;
    cur_c = 0;
  endfunction

  // Returns 1 when the line feed pushed the cursor past the last row.
  function automatic bit next_line();
    int unsigned base;
    cur_c = 0;
    cur_r++;
    if (cur_r < rows_eff()) return 1'b0;
    top_ofs = (top_ofs + 1) % MaxRows;
    base = cell_addr(rows_eff() - 1, 0);
    for (int i = 0; i < MaxCols; i++) screen[base + i] = CH_SPACE;
    cur_r = rows_eff() - 1;
    return 1'b1;
  endfunction

  function automatic void pull_cursor_inside();
    if (cur_r >= rows_eff()) cur_r = rows_eff() - 1;
    if (cur_c >= cols_eff()) cur_c = cols_eff() - 1;
  endfunction

  function automatic res_t console_step(action_e act, logic [7:0] ch,
                                        logic [RowW-1:0] rrow,
                                        logic [ColW-1:0] rcol);
    res_t r;
    r = '0;
    case (act)
      ACT_PUT: begin
        if (ch == CH_LF) begin
          r.scrolled = next_line();
        end else if (ch == CH_BS) begin
          if (cur_c != 0) begin
            cur_c--;
            screen[cell_addr(cur_r, cur_c)] = CH_SPACE;
          end
        end else if (ch != CH_CR) begin
          if (cur_c >= cols_eff()) begin
            if (next_line()) r.scrolled = 1'b1;
          end
          screen[cell_addr(cur_r, cur_c)] = ch;
          cur_c++;
          if (cur_c >= cols_eff()) begin
            if (next_line()) r.scrolled = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (rrow < rows_eff() && rcol < cols_eff()) begin
          r.cell_char = screen[cell_addr(rrow, rcol)];
        end else begin
          r.cell_char = CH_SPACE;
        end
      end
      ACT_CLEAR: wipe_screen();
      default: ;
    endcase
    r.cursor_row    = RowW'(cur_r);
    r.cursor_column = ColW'(cur_c);
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic console_item_t make_item(action_e act, logic [7:0] ch,
                                              int unsigned rrow, int unsigned rcol);
    console_item_t it;
    it.act  = act;
    it.ch   = ch;
    it.rrow = RowW'(rrow);
    it.rcol = ColW'(rcol);
    return it;
  endfunction

  // Mostly text with line control and in-grid reads; some raw bytes,
  // out-of-grid reads, no-ops and clears.
  function automatic console_item_t random_item();
    console_item_t it;
    int unsigned   roll;
    it = make_item(ACT_PUT, 8'($urandom_range(32, 126)), $urandom, $urandom);
    roll = $urandom_range(0, 999);
    if (roll < 600) begin
    end else if (roll < 680) begin
      it.ch = CH_LF;
    end else if (roll < 740) begin
      it.ch = CH_BS;
    end else if (roll < 770) begin
      it.ch = CH_CR;
    end else if (roll < 830) begin
      it.ch = 8'($urandom_range(0, 255));
    end else if (roll < 970) begin
      it.act = ACT_READ;
      if ($urandom_range(0, 4) != 0) begin
        it.rrow = RowW'($urandom_range(0, rows_eff() - 1));
        it.rcol = ColW'($urandom_range(0, cols_eff() - 1));
      end
    end else if (roll < 985) begin
      it.act = ACT_NONE;
      it.ch  = 8'($urandom);
    end else begin
      it.act = ACT_CLEAR;
    end
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic write_reg(input logic [2:0] addr, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_COLUMNS) begin
      col_setting = value & 8'hFF;
    end else begin
      row_setting = value & 7'h7F;
    end
    pull_cursor_inside();
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_random(input int count);
    repeat (count) pending.push_back(random_item());
  endtask

  // Driver: predicts each accepted beat, then presents the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        results_due.push_back(console_step(action_e'(action_i), char_code_i,
                                           read_row_i, read_column_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0) begin
          console_item_t it;
          it = pending.pop_front();
          action_i      <= it.act;
          char_code_i   <= it.ch;
          read_row_i    <= it.rrow;
          read_column_i <= it.rcol;
          in_valid_i    <= 1'b1;
          send_gap      <= send_idle ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, including the long hold requested by the sequence.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap    <= recv_idle ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        note_mismatch("result beat with no item outstanding");
      end else begin
        res_t exp_res;
        exp_res = results_due.pop_front();
        if (cell_char_o !== exp_res.cell_char)
          note_mismatch($sformatf("cell_char %0h, expected %0h",
                                  cell_char_o, exp_res.cell_char));
        if (cursor_row_o !== exp_res.cursor_row)
          note_mismatch($sformatf("cursor_row %0d, expected %0d",
                                  cursor_row_o, exp_res.cursor_row));
        if (cursor_column_o !== exp_res.cursor_column)
          note_mismatch($sformatf("cursor_column %0d, expected %0d",
                                  cursor_column_o, exp_res.cursor_column));
        if (scrolled_o !== exp_res.scrolled)
          note_mismatch($sformatf("scrolled %0b, expected %0b",
                                  scrolled_o, exp_res.scrolled));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned cols;
    int unsigned rows;
    wipe_screen();
    col_setting = MaxCols;
    row_setting = MaxRows;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Default geometry: plain text, ignored carriage return, backspace in
    // and at the start of a row, reads at the grid corners, no-op, clear.
    pending.push_back(make_item(ACT_PUT, 8'h48, 0, 0));
    pending.push_back(make_item(ACT_PUT, 8'hFF, 0, 0));
    pending.push_back(make_item(ACT_PUT, 8'h00, 0, 0));
    pending.push_back(make_item(ACT_PUT, CH_CR, 0, 0));
    pending.push_back(make_item(ACT_PUT, CH_BS, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 0, 1));
    pending.push_back(make_item(ACT_READ, 8'h00, 0, 2));
    pending.push_back(make_item(ACT_PUT, CH_LF, 0, 0));
    pending.push_back(make_item(ACT_PUT, CH_BS, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'hFF, 63, 127));
    pending.push_back(make_item(ACT_NONE, 8'hFF, 63, 127));
    pending.push_back(make_item(ACT_PUT, 8'h7F, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 1, 0));
    pending.push_back(make_item(ACT_CLEAR, 8'h00, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 0, 0));
    wait_drained();

    // Zero registers act as a one-by-one grid: every character put and line feed scrolls.
    write_reg(ADDR_COLUMNS, 0);
    write_reg(ADDR_ROWS, 0);
    pending.push_back(make_item(ACT_PUT, 8'h41, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 1, 0));
    pending.push_back(make_item(ACT_PUT, CH_LF, 0, 0));
    pending.push_back(make_item(ACT_PUT, CH_BS, 0, 0));
    wait_drained();

    write_reg(ADDR_COLUMNS, 3);
    write_reg(ADDR_ROWS, 2);
    pending.push_back(make_item(ACT_PUT, 8'h78, 0, 0));
    pending.push_back(make_item(ACT_PUT, 8'h79, 0, 0));
    pending.push_back(make_item(ACT_PUT, 8'h7A, 0, 0));
    pending.push_back(make_item(ACT_READ, 8'h00, 0, 2));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cols = 255; rows = 127; end
        1: begin cols = 40;  rows = 8;   end
        2: begin cols = 4;   rows = 3;   end
        3: begin cols = 1;   rows = 64;  end
        4: begin cols = 128; rows = 1;   end
        5: begin cols = 80;  rows = 2;   end
        6: begin cols = 2;   rows = 5;   end
        7: begin cols = 16;  rows = 4;   end
        8: begin cols = 3;   rows = 2;   end
        default: begin
          cols = $urandom_range(0, 255);
          rows = $urandom_range(0, 127);
        end
      endcase
      write_reg(ADDR_COLUMNS, cols);
      write_reg(ADDR_ROWS, rows);
      send_idle = (p != 1 && p != 3);
      recv_idle = (p != 1);
      if (p == 3) begin
        // The receiver stalls for a long stretch while beats keep coming.
        hold_requests++;
        push_random(PHASE_ITEMS);
      end else if (p == 5) begin
        push_random(PHASE_ITEMS / 2);
        wait_drained();
        push_random(PHASE_ITEMS / 2);
      end else begin
        push_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
